FILE: rtl/sts_pkg.sv
// ---------------------------------------------------------------------------
// sts_pkg
// Shared types and constants for the sorted table block search.
// ---------------------------------------------------------------------------
`default_nettype none

package sts_pkg;

  localparam int KEY_W     = 37;
  localparam int SHORT_W   = 34;
  localparam int INDEX_W   = 14;
  localparam int CNT_W     = 32;
  localparam int BIU_W     = 8;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = 1;

  localparam logic [BIU_W-1:0]     BIU_RESET         = 8'd128;
  localparam logic [REG_IDX_W-1:0] REG_BLOCKS_IN_USE = 1'b0;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_QUERY  = 1'b1;
  localparam logic TBL_SHORT = 1'b0;
  localparam logic TBL_LONG  = 1'b1;

  typedef struct packed {
    logic               operation;
    logic               table_select;
    logic [INDEX_W-1:0] entry_index;
    logic [KEY_W-1:0]   key;
  } in_item_t;

  typedef struct packed {
    logic             found;
    logic [CNT_W-1:0] queries_so_far;
    logic [CNT_W-1:0] hits_so_far;
  } result_t;

  // search outcome from the sequencer
  typedef struct packed {
    logic valid;
    logic found;
  } search_status_t;

endpackage

`default_nettype wire

FILE: rtl/sorted_table_block_search_top.sv
// ---------------------------------------------------------------------------
// sorted_table_block_search_top
// Two sorted key tables with jump search over fixed-size blocks.
// Load: no result, busy stays low.
// Query: busy while up to nb block heads and then one block are searched,
// nb being blocks_in_use clamped to 1..TABLE_ENTRIES/BLOCK_SIZE; one table
// entry is read and compared per cycle. done pulses in the cycle after busy
// falls; the next item may be taken as soon as busy is low.
// Sync reset: counters zero, blocks_in_use 128; table contents undefined.
// ---------------------------------------------------------------------------
`default_nettype none

module sorted_table_block_search_top #(
  parameter int TABLE_ENTRIES = 16384,
  parameter int BLOCK_SIZE    = 128
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output      logic                          busy,
  input  wire sts_pkg::in_item_t             item,
  output      logic                          done,
  output      sts_pkg::result_t              result,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [sts_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [sts_pkg::PDATA_W-1:0]   pwdata,
  output      logic [sts_pkg::PDATA_W-1:0]   prdata,
  output      logic                          pready
);
  import sts_pkg::*;

  localparam int ADDR_W     = $clog2(TABLE_ENTRIES);
  localparam int MAX_BLOCKS = TABLE_ENTRIES / BLOCK_SIZE;

  logic [BIU_W-1:0]     blocks_in_use;
  logic [BIU_W-1:0]     nb;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 accept;
  logic                 query_go;
  logic                 wr_en;
  logic                 sel_q;
  logic                 rd_en;
  logic [ADDR_W-1:0]    rd_addr;
  logic [KEY_W-1:0]     rd_data;
  logic                 busy_int;
  search_status_t       status;
  logic [CNT_W-1:0]     short_query_count;
  logic [CNT_W-1:0]     short_hit_count;
  logic [CNT_W-1:0]     long_query_count;
  logic [CNT_W-1:0]     long_hit_count;
  logic [CNT_W-1:0]     q_next;
  logic [CNT_W-1:0]     h_next;

  assign reg_idx = paddr[PADDR_W-1:2];
  assign pready  = 1'b1;
  assign prdata  = (reg_idx == REG_BLOCKS_IN_USE) ? PDATA_W'(blocks_in_use) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      blocks_in_use <= BIU_RESET;
    end else if (psel && penable && pwrite && reg_idx == REG_BLOCKS_IN_USE) begin
      blocks_in_use <= pwdata[BIU_W-1:0];
    end
  end

  always_comb begin
    if (blocks_in_use == '0) begin
      nb = BIU_W'(1);
    end else if (32'(blocks_in_use) > 32'(MAX_BLOCKS)) begin
      nb = BIU_W'(MAX_BLOCKS);
    end else begin
      nb = blocks_in_use;
    end
  end

  assign busy     = busy_int;
  assign accept   = start && !busy_int;
  assign query_go = accept && item.operation == OP_QUERY;
  assign wr_en    = accept && item.operation == OP_LOAD &&
                    32'(item.entry_index) < 32'(TABLE_ENTRIES);

  always_ff @(posedge clk) begin
    if (query_go) begin
      sel_q <= item.table_select;
    end
  end

  sts_key_store #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .ADDR_W        (ADDR_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_sel  (item.table_select),
    .wr_addr (ADDR_W'(item.entry_index)),
    .wr_key  (item.key),
    .rd_en   (rd_en),
    .rd_sel  (sel_q),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  sts_search_ctrl #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .BLOCK_SIZE    (BLOCK_SIZE),
    .ADDR_W        (ADDR_W)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (query_go),
    .key     (item.key),
    .nb      (nb),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .busy    (busy_int),
    .status  (status)
  );

  always_comb begin
    if (sel_q == TBL_LONG) begin
      q_next = long_query_count + 1'b1;
      h_next = long_hit_count + CNT_W'(status.found);
    end else begin
      q_next = short_query_count + 1'b1;
      h_next = short_hit_count + CNT_W'(status.found);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      short_query_count <= '0;
      short_hit_count   <= '0;
      long_query_count  <= '0;
      long_hit_count    <= '0;
      done              <= 1'b0;
    end else begin
      done <= status.valid;
      if (status.valid) begin
        if (sel_q == TBL_LONG) begin
          long_query_count <= q_next;
          long_hit_count   <= h_next;
        end else begin
          short_query_count <= q_next;
          short_hit_count   <= h_next;
        end
        result.found          <= status.found;
        result.queries_so_far <= q_next;
        result.hits_so_far    <= h_next;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/sts_key_store.sv
// ---------------------------------------------------------------------------
// sts_key_store
// Both key tables: one write port, one registered read port each.
// ---------------------------------------------------------------------------
`default_nettype none

module sts_key_store #(
  parameter int TABLE_ENTRIES = 16384,
  parameter int ADDR_W        = $clog2(TABLE_ENTRIES)
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic                     wr_sel,
  input  wire logic [ADDR_W-1:0]        wr_addr,
  input  wire logic [sts_pkg::KEY_W-1:0] wr_key,
  input  wire logic                     rd_en,
  input  wire logic                     rd_sel,
  input  wire logic [ADDR_W-1:0]        rd_addr,
  output      logic [sts_pkg::KEY_W-1:0] rd_data
);
  import sts_pkg::*;

  logic [SHORT_W-1:0] short_mem [TABLE_ENTRIES];
  logic [KEY_W-1:0]   long_mem  [TABLE_ENTRIES];
  logic [SHORT_W-1:0] short_rd;
  logic [KEY_W-1:0]   long_rd;
  logic               rd_sel_q;

  always_ff @(posedge clk) begin
    if (wr_en && wr_sel == TBL_SHORT) begin
      short_mem[wr_addr] <= wr_key[SHORT_W-1:0];
    end
    if (rd_en && rd_sel == TBL_SHORT) begin
      short_rd <= short_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && wr_sel == TBL_LONG) begin
      long_mem[wr_addr] <= wr_key;
    end
    if (rd_en && rd_sel == TBL_LONG) begin
      long_rd <= long_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_sel_q <= rd_sel;
    end
  end

  assign rd_data = (rd_sel_q == TBL_LONG) ? long_rd : {{(KEY_W-SHORT_W){1'b0}}, short_rd};

endmodule

`default_nettype wire

FILE: rtl/sts_search_ctrl.sv
// ---------------------------------------------------------------------------
// sts_search_ctrl
// Jump search sequencer: walks block heads, then, unless a head settles the
// query, scans one block, one table read and one key compare per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module sts_search_ctrl #(
  parameter int TABLE_ENTRIES = 16384,
  parameter int BLOCK_SIZE    = 128,
  parameter int ADDR_W        = $clog2(TABLE_ENTRIES)
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [sts_pkg::KEY_W-1:0]  key,
  input  wire logic [sts_pkg::BIU_W-1:0]  nb,
  output      logic                       rd_en,
  output      logic [ADDR_W-1:0]          rd_addr,
  input  wire logic [sts_pkg::KEY_W-1:0]  rd_data,
  output      logic                       busy,
  output      sts_pkg::search_status_t    status
);
  import sts_pkg::*;

  localparam int MAX_BLOCKS = TABLE_ENTRIES / BLOCK_SIZE;
  localparam int SCAN_W     = $clog2(BLOCK_SIZE);
  localparam logic [SCAN_W-1:0] SCAN_CNT = SCAN_W'(BLOCK_SIZE - 1);
  localparam logic [SCAN_W-1:0] SCAN_ONE = SCAN_W'(1);
  localparam logic [ADDR_W-1:0] BS_ADDR  = ADDR_W'(BLOCK_SIZE);
  localparam logic [ADDR_W-1:0] ADDR_ONE = ADDR_W'(1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_HEAD,
    S_SCAN
  } state_t;

  state_t             state;
  logic [KEY_W-1:0]   key_q;
  logic [BIU_W-1:0]   nb_q;
  logic [ADDR_W-1:0]  head_addr;
  logic [ADDR_W-1:0]  last_addr;
  logic [BIU_W-1:0]   heads_left;
  logic [BIU_W-1:0]   cmp_blk;
  logic [ADDR_W-1:0]  scan_addr;
  logic [SCAN_W-1:0]  scan_left;
  logic [SCAN_W-1:0]  cmp_left;
  logic               pend;

  assign rd_en   = (state == S_HEAD && heads_left != '0) ||
                   (state == S_SCAN && scan_left != '0);
  assign rd_addr = (state == S_SCAN) ? scan_addr : head_addr;
  assign busy    = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      pend   <= 1'b0;
      status <= '0;
    end else begin
      status.valid <= 1'b0;
      pend         <= rd_en;
      if (rd_en && state == S_HEAD) begin
        head_addr  <= head_addr + BS_ADDR;
        last_addr  <= head_addr;
        heads_left <= heads_left - 1'b1;
      end
      if (rd_en && state == S_SCAN) begin
        scan_addr <= scan_addr + ADDR_ONE;
        scan_left <= scan_left - SCAN_ONE;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            key_q <= key;
            nb_q  <= nb;
            if (MAX_BLOCKS == 0) begin
              status.valid <= 1'b1;
              status.found <= 1'b0;
            end else begin
              state      <= S_HEAD;
              head_addr  <= '0;
              heads_left <= nb;
              cmp_blk    <= '0;
            end
          end
        end
        S_HEAD: begin
          if (pend) begin
            if (key_q < rd_data) begin
              pend <= 1'b0;
              if (cmp_blk == '0) begin
                state        <= S_IDLE;
                status.valid <= 1'b1;
                status.found <= 1'b0;
              end else begin
                state     <= S_SCAN;
                scan_addr <= last_addr - BS_ADDR + ADDR_ONE;
                scan_left <= SCAN_CNT;
                cmp_left  <= SCAN_CNT;
              end
            end else if (key_q == rd_data) begin
              pend         <= 1'b0;
              state        <= S_IDLE;
              status.valid <= 1'b1;
              status.found <= 1'b1;
            end else if (cmp_blk == nb_q - 1'b1) begin
              pend      <= 1'b0;
              state     <= S_SCAN;
              scan_addr <= last_addr + ADDR_ONE;
              scan_left <= SCAN_CNT;
              cmp_left  <= SCAN_CNT;
            end else begin
              cmp_blk <= cmp_blk + 1'b1;
            end
          end
        end
        S_SCAN: begin
          if (pend) begin
            cmp_left <= cmp_left - SCAN_ONE;
            if (rd_data == key_q) begin
              pend         <= 1'b0;
              state        <= S_IDLE;
              status.valid <= 1'b1;
              status.found <= 1'b1;
            end else if (cmp_left == SCAN_ONE) begin
              pend         <= 1'b0;
              state        <= S_IDLE;
              status.valid <= 1'b1;
              status.found <= 1'b0;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
